// ===== design/ffca_pkg.sv =====
// shared constants and codes for the first-fit chunk allocator
// no dependencies; used by the allocator top level
`default_nettype none

package ffca_pkg;

    localparam int ADDR_W      = 48;
    localparam int SIZE_W      = 28;
    localparam int INDEX_W     = 10;
    localparam int STATUS_W    = 2;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 64;

    localparam int CHUNK_TOTAL_DEF = 1024;
    localparam int CHUNK_BYTES     = 128 * 1024;
    localparam int CHUNK_SHIFT     = $clog2(CHUNK_BYTES);

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_ROOM = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD     = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // register select is paddr bit 3 (8-byte register slots)
    localparam logic REG_HEAP_BASE = 1'b0;

endpackage

`default_nettype wire

// ===== design/ffca_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module ffca_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/first_fit_chunk_allocator_core.sv =====
// first-fit chunk allocator: used-bit map in ram, sequencer walks it one chunk a cycle
// allocate: run scan, then mark, then a hint scan when the run began at the hint
// free: offset subtract, check, clear; one beat in flight at a time, output register after
// the ram read port and its one-chunk-per-cycle walk set the rate
// reset: after rst_n the map is cleared one chunk a cycle, input stalled
// depends on ffca_pkg and ffca_ram
`default_nettype none

module first_fit_chunk_allocator_core #(
    parameter int CHUNK_TOTAL = ffca_pkg::CHUNK_TOTAL_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ffca_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [ffca_pkg::PDATA_W-1:0]      pwdata,
    output logic      [ffca_pkg::PDATA_W-1:0]      prdata,
    output logic                                   pready,

    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              command,
    input  wire logic [ffca_pkg::SIZE_W-1:0]       byte_size,
    input  wire logic [ffca_pkg::ADDR_W-1:0]       free_address,

    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [ffca_pkg::STATUS_W-1:0]     status,
    output logic      [ffca_pkg::INDEX_W-1:0]      chunk_index,
    output logic      [ffca_pkg::ADDR_W-1:0]       address
);

    localparam int ADDR_W   = ffca_pkg::ADDR_W;
    localparam int SHIFT    = ffca_pkg::CHUNK_SHIFT;
    localparam int IDX_W    = (CHUNK_TOTAL > 1) ? $clog2(CHUNK_TOTAL) : 1;
    localparam int HINT_W   = $clog2(CHUNK_TOTAL + 1);
    localparam int CHUNKS_W = ffca_pkg::SIZE_W - SHIFT;
    localparam int EXT_W    = ((HINT_W > CHUNKS_W) ? HINT_W : CHUNKS_W) + 1;
    localparam int IDXF_W   = ADDR_W - SHIFT;

    localparam logic [HINT_W-1:0] TOTAL_H = HINT_W'(CHUNK_TOTAL);
    localparam logic [IDX_W-1:0]  LAST_I  = IDX_W'(CHUNK_TOTAL - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_START,
        S_A_SCAN,
        S_A_MARK,
        S_A_HINT,
        S_F_SUB,
        S_F_CHK,
        S_F_CLR,
        S_RESULT
    } state_t;

    state_t                          state_reg, state_next;
    logic                            cmd_reg, cmd_next;
    logic [CHUNKS_W-1:0]             chunks_reg, chunks_next;
    logic [ADDR_W-1:0]               faddr_reg, faddr_next;
    logic                            below_reg, below_next;
    logic [ADDR_W-1:0]               base_reg, base_next;
    logic [HINT_W-1:0]               hint_reg, hint_next;
    logic [HINT_W-1:0]               scan_p_reg, scan_p_next;
    logic [IDX_W-1:0]                chk_p_reg, chk_p_next;
    logic                            chk_vld_reg, chk_vld_next;
    logic [HINT_W-1:0]               run_reg, run_next;
    logic [HINT_W-1:0]               mark_p_reg, mark_p_next;
    logic [HINT_W-1:0]               mark_left_reg, mark_left_next;
    logic [ffca_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [IDX_W-1:0]                res_idx_reg, res_idx_next;
    logic                            out_valid_reg, out_valid_next;
    logic [ffca_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [ffca_pkg::INDEX_W-1:0]    chunk_index_reg, chunk_index_next;
    logic [ADDR_W-1:0]               address_reg, address_next;

    // shared adder: offset subtract on free, base plus chunk offset for the result
    logic [ADDR_W-1:0]  add_a;
    logic [ADDR_W-1:0]  add_b;
    logic               add_cin;
    logic [ADDR_W:0]    add_sum;

    logic               ram_we;
    logic [0:0]         ram_wdata;
    logic [0:0]         ram_rdata;

    logic               issue;
    logic [HINT_W-1:0]  run_new;
    logic [HINT_W-1:0]  start_pos;
    logic [HINT_W-1:0]  chunks_h;
    logic [IDXF_W-1:0]  idx_full;
    logic               cfg_wr;

    ffca_ram #(
        .WIDTH (1),
        .DEPTH (CHUNK_TOTAL)
    ) u_used_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (mark_p_reg[IDX_W-1:0]),
        .wdata (ram_wdata),
        .raddr (scan_p_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[3] == ffca_pkg::REG_HEAP_BASE);
    assign prdata   = (paddr[3] == ffca_pkg::REG_HEAP_BASE) ?
                      ffca_pkg::PDATA_W'(base_reg) : '0;

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign chunk_index = chunk_index_reg;
    assign address     = address_reg;

    assign add_sum  = {1'b0, add_a} + {1'b0, add_b} + {{ADDR_W{1'b0}}, add_cin};
    assign issue    = (scan_p_reg != TOTAL_H);
    assign chunks_h = HINT_W'(chunks_reg);
    assign run_new  = ram_rdata[0] ? '0 : (run_reg + HINT_W'(1));
    assign start_pos = HINT_W'(chk_p_reg) + HINT_W'(1) - chunks_h;
    assign idx_full = faddr_reg[ADDR_W-1:SHIFT];

    always_comb
    begin
        if (state_reg == S_F_SUB)
        begin
            add_a   = faddr_reg;
            add_b   = ~base_reg;
            add_cin = 1'b1;
        end
        else
        begin
            add_a   = base_reg;
            add_b   = ADDR_W'(res_idx_reg) << SHIFT;
            add_cin = 1'b0;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        chunks_next      = chunks_reg;
        faddr_next       = faddr_reg;
        below_next       = below_reg;
        base_next        = base_reg;
        hint_next        = hint_reg;
        scan_p_next      = scan_p_reg;
        chk_p_next       = chk_p_reg;
        chk_vld_next     = chk_vld_reg;
        run_next         = run_reg;
        mark_p_next      = mark_p_reg;
        mark_left_next   = mark_left_reg;
        res_status_next  = res_status_reg;
        res_idx_next     = res_idx_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        chunk_index_next = chunk_index_reg;
        address_next     = address_reg;
        ram_we           = 1'b0;
        ram_wdata        = 1'b0;

        if (cfg_wr)
        begin
            base_next = pwdata[ADDR_W-1:0];
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_we      = 1'b1;
                ram_wdata   = 1'b0;
                mark_p_next = mark_p_reg + HINT_W'(1);
                if (mark_p_reg == TOTAL_H - HINT_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next        = command;
                    chunks_next     = byte_size[ffca_pkg::SIZE_W-1:SHIFT];
                    faddr_next      = free_address;
                    res_status_next = ffca_pkg::STATUS_BAD;
                    res_idx_next    = '0;
                    state_next      = (command == ffca_pkg::CMD_ALLOC) ? S_A_START : S_F_SUB;
                end
            end

            S_A_START:
            begin
                if (chunks_reg == '0)
                begin
                    res_status_next = ffca_pkg::STATUS_BAD;
                    state_next      = S_RESULT;
                end
                else if ((EXT_W'(chunks_reg) > EXT_W'(CHUNK_TOTAL)) || (hint_reg == TOTAL_H))
                begin
                    res_status_next = ffca_pkg::STATUS_NO_ROOM;
                    state_next      = S_RESULT;
                end
                else
                begin
                    scan_p_next  = hint_reg;
                    chk_vld_next = 1'b0;
                    run_next     = '0;
                    state_next   = S_A_SCAN;
                end
            end

            S_A_SCAN:
            begin
                chk_vld_next = issue;
                chk_p_next   = scan_p_reg[IDX_W-1:0];
                scan_p_next  = scan_p_reg + HINT_W'(issue);
                if (chk_vld_reg)
                begin
                    run_next = run_new;
                    if (run_new == chunks_h)
                    begin
                        res_status_next = ffca_pkg::STATUS_OK;
                        res_idx_next    = start_pos[IDX_W-1:0];
                        mark_p_next     = start_pos;
                        mark_left_next  = chunks_h;
                        state_next      = S_A_MARK;
                    end
                    else if (chk_p_reg == LAST_I)
                    begin
                        res_status_next = ffca_pkg::STATUS_NO_ROOM;
                        state_next      = S_RESULT;
                    end
                end
            end

            S_A_MARK:
            begin
                ram_we         = 1'b1;
                ram_wdata      = 1'b1;
                mark_p_next    = mark_p_reg + HINT_W'(1);
                mark_left_next = mark_left_reg - HINT_W'(1);
                if (mark_left_reg == HINT_W'(1))
                begin
                    if (HINT_W'(res_idx_reg) != hint_reg)
                    begin
                        state_next = S_RESULT;
                    end
                    else if (mark_p_next == TOTAL_H)
                    begin
                        hint_next  = TOTAL_H;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        // hint walks up from the end of the new run
                        scan_p_next  = mark_p_next;
                        chk_vld_next = 1'b0;
                        state_next   = S_A_HINT;
                    end
                end
            end

            S_A_HINT:
            begin
                chk_vld_next = issue;
                chk_p_next   = scan_p_reg[IDX_W-1:0];
                scan_p_next  = scan_p_reg + HINT_W'(issue);
                if (chk_vld_reg)
                begin
                    if (!ram_rdata[0])
                    begin
                        hint_next  = HINT_W'(chk_p_reg);
                        state_next = S_RESULT;
                    end
                    else if (chk_p_reg == LAST_I)
                    begin
                        hint_next  = TOTAL_H;
                        state_next = S_RESULT;
                    end
                end
            end

            S_F_SUB:
            begin
                faddr_next = add_sum[ADDR_W-1:0];
                below_next = !add_sum[ADDR_W];
                state_next = S_F_CHK;
            end

            S_F_CHK:
            begin
                if (below_reg)
                begin
                    res_status_next = ffca_pkg::STATUS_BAD;
                    state_next      = S_RESULT;
                end
                else if (idx_full >= IDXF_W'(CHUNK_TOTAL))
                begin
                    res_status_next = ffca_pkg::STATUS_BAD;
                    state_next      = S_RESULT;
                end
                else if ((EXT_W'(idx_full[IDX_W-1:0]) + EXT_W'(chunks_reg)) >
                         EXT_W'(CHUNK_TOTAL))
                begin
                    res_status_next = ffca_pkg::STATUS_BAD;
                    state_next      = S_RESULT;
                end
                else
                begin
                    res_status_next = ffca_pkg::STATUS_OK;
                    res_idx_next    = idx_full[IDX_W-1:0];
                    if (chunks_reg == '0)
                    begin
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        mark_p_next    = HINT_W'(idx_full[IDX_W-1:0]);
                        mark_left_next = chunks_h;
                        if (HINT_W'(idx_full[IDX_W-1:0]) < hint_reg)
                        begin
                            hint_next = HINT_W'(idx_full[IDX_W-1:0]);
                        end
                        state_next = S_F_CLR;
                    end
                end
            end

            S_F_CLR:
            begin
                ram_we         = 1'b1;
                ram_wdata      = 1'b0;
                mark_p_next    = mark_p_reg + HINT_W'(1);
                mark_left_next = mark_left_reg - HINT_W'(1);
                if (mark_left_reg == HINT_W'(1))
                begin
                    state_next = S_RESULT;
                end
            end

            S_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    if (res_status_reg == ffca_pkg::STATUS_OK)
                    begin
                        chunk_index_next = ffca_pkg::INDEX_W'(res_idx_reg);
                        address_next     = add_sum[ADDR_W-1:0];
                    end
                    else
                    begin
                        chunk_index_next = '0;
                        address_next     = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            cmd_reg         <= ffca_pkg::CMD_ALLOC;
            chunks_reg      <= '0;
            faddr_reg       <= '0;
            below_reg       <= 1'b0;
            base_reg        <= '0;
            hint_reg        <= '0;
            scan_p_reg      <= '0;
            chk_p_reg       <= '0;
            chk_vld_reg     <= 1'b0;
            run_reg         <= '0;
            mark_p_reg      <= '0;
            mark_left_reg   <= '0;
            res_status_reg  <= ffca_pkg::STATUS_OK;
            res_idx_reg     <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= ffca_pkg::STATUS_OK;
            chunk_index_reg <= '0;
            address_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cmd_reg         <= cmd_next;
            chunks_reg      <= chunks_next;
            faddr_reg       <= faddr_next;
            below_reg       <= below_next;
            base_reg        <= base_next;
            hint_reg        <= hint_next;
            scan_p_reg      <= scan_p_next;
            chk_p_reg       <= chk_p_next;
            chk_vld_reg     <= chk_vld_next;
            run_reg         <= run_next;
            mark_p_reg      <= mark_p_next;
            mark_left_reg   <= mark_left_next;
            res_status_reg  <= res_status_next;
            res_idx_reg     <= res_idx_next;
            out_valid_reg   <= out_valid_next;
            status_reg      <= status_next;
            chunk_index_reg <= chunk_index_next;
            address_reg     <= address_next;
        end
    end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking testbench for first_fit_chunk_allocator_core: directed and random requests
// go through a bit-level allocator predictor, results are compared beat by beat
// depends on ffca_pkg and the allocator rtl
`timescale 1ns / 100ps

module testbench;

    localparam int ADDR_W      = ffca_pkg::ADDR_W;
    localparam int SIZE_W      = ffca_pkg::SIZE_W;
    localparam int INDEX_W     = ffca_pkg::INDEX_W;
    localparam int STATUS_W    = ffca_pkg::STATUS_W;
    localparam int PADDR_W     = ffca_pkg::PADDR_W;
    localparam int PDATA_W     = ffca_pkg::PDATA_W;
    localparam int CHUNK_BYTES = ffca_pkg::CHUNK_BYTES;

    localparam int CHUNK_TOTAL = ffca_pkg::CHUNK_TOTAL_DEF;
    localparam int POOL_BYTES = CHUNK_TOTAL * CHUNK_BYTES;
    localparam longint CYCLE_LIMIT = 10_000_000;
    localparam logic [PADDR_W-1:0] HEAP_BASE_ADDR = {ffca_pkg::REG_HEAP_BASE, 3'b000};
    localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  chunk_index;
        logic [ADDR_W-1:0]   address;
    } alloc_result_t;

    typedef struct {
        int first;
        int count;
    } region_t;

    logic clk = 1'b0;
    logic rst_n;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    logic               in_valid;
    logic               in_stall;
    logic               command;
    logic [SIZE_W-1:0]  byte_size;
    logic [ADDR_W-1:0]  free_address;

    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  chunk_index;
    logic [ADDR_W-1:0]   address;

    // predictor state
    bit                chunk_used [CHUNK_TOTAL];
    int                scan_hint;
    logic [ADDR_W-1:0] model_base;

    alloc_result_t expected_results [$];
    region_t       live_regions [$];

    bit     source_quiet;
    bit     sink_quiet;
    int     fail_count;
    longint cycle_count;
    int     request_count;
    int     alloc_granted;
    int     frees_done;
    int     no_room_seen;
    int     bad_seen;
    int     base_writes;

    first_fit_chunk_allocator_core #(
        .CHUNK_TOTAL(CHUNK_TOTAL)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .byte_size   (byte_size),
        .free_address(free_address),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .chunk_index (chunk_index),
        .address     (address)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic alloc_result_t predict_allocator(input logic cmd,
                                                        input logic [SIZE_W-1:0] size,
                                                        input logic [ADDR_W-1:0] faddr);
        alloc_result_t r;
        longint unsigned chunks;
        longint unsigned run;
        longint unsigned start;
        longint unsigned idx;
        int p;
        bit found;
        r.status = ffca_pkg::STATUS_BAD;
        r.chunk_index = '0;
        r.address = '0;
        chunks = size / CHUNK_BYTES;
        if (cmd == ffca_pkg::CMD_ALLOC)
        begin
            if (chunks == 0)
                return r;
            r.status = ffca_pkg::STATUS_NO_ROOM;
            if (chunks > CHUNK_TOTAL)
                return r;
            run = 0;
            start = 0;
            found = 1'b0;
            for (p = scan_hint; p < CHUNK_TOTAL && !found; p++)
            begin
                run = chunk_used[p] ? 0 : run + 1;
                if (run == chunks)
                begin
                    start = p + 1 - chunks;
                    found = 1'b1;
                end
            end
            if (!found)
                return r;
            for (p = int'(start); p < start + chunks; p++)
                chunk_used[p] = 1'b1;
            // hint only moves when the run began at it
            if (start == scan_hint)
                while (scan_hint < CHUNK_TOTAL && chunk_used[scan_hint])
                    scan_hint++;
            idx = start;
        end
        else
        begin
            if (faddr < model_base)
                return r;
            idx = (faddr - model_base) / CHUNK_BYTES;
            if (idx >= CHUNK_TOTAL || idx + chunks > CHUNK_TOTAL)
                return r;
            if (chunks > 0)
            begin
                for (p = int'(idx); p < idx + chunks; p++)
                    chunk_used[p] = 1'b0;
                if (idx < scan_hint)
                    scan_hint = int'(idx);
            end
        end
        r.status = ffca_pkg::STATUS_OK;
        r.chunk_index = idx[INDEX_W-1:0];
        r.address = ADDR_W'(model_base + idx * CHUNK_BYTES);
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] random_address();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    // whole chunks plus a partial tail that divides away; the full pool size for n of CHUNK_TOTAL or more
    function automatic logic [SIZE_W-1:0] chunk_bytes_of(input int n);
        if (n >= CHUNK_TOTAL)
            return SIZE_W'(POOL_BYTES);
        return SIZE_W'(n * CHUNK_BYTES + $urandom_range(0, CHUNK_BYTES - 1));
    endfunction

    // random backpressure on the result side
    initial
    begin : sink_stall
        int hold;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!sink_quiet && $urandom_range(0, 3) == 0)
            begin
                hold = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(1, 3);
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // sampled at the falling edge, the beat is taken at the next rising edge
    always @(negedge clk)
    begin : result_check
        alloc_result_t want;
        if (out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with no request outstanding");
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    fail_count++;
                end
                if (chunk_index !== want.chunk_index)
                begin
                    $error("chunk_index: expected %0d, got %0d", want.chunk_index, chunk_index);
                    fail_count++;
                end
                if (address !== want.address)
                begin
                    $error("address: expected %h, got %h", want.address, address);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_request(input logic cmd, input logic [SIZE_W-1:0] size,
                                input logic [ADDR_W-1:0] faddr, output alloc_result_t outcome);
        int gap;
        bit taken;
        if (!source_quiet)
        begin
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50) :
                  ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        command <= cmd;
        byte_size <= size;
        free_address <= faddr;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end while (!taken);
        outcome = predict_allocator(cmd, size, faddr);
        expected_results.push_back(outcome);
        request_count++;
        case (outcome.status)
            ffca_pkg::STATUS_OK:
                if (cmd == ffca_pkg::CMD_ALLOC)
                    alloc_granted++;
                else
                    frees_done++;
            ffca_pkg::STATUS_NO_ROOM: no_room_seen++;
            default: bad_seen++;
        endcase
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_heap_base(input logic [ADDR_W-1:0] value);
        logic rdy;
        logic [PDATA_W-1:0] rd;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= HEAP_BASE_ADDR;
        pwdata <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            rdy = pready;
            @(posedge clk);
        end while (!rdy);
        model_base = value;
        base_writes++;
        // read it back
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            rdy = pready;
            rd = prdata;
            @(posedge clk);
        end while (!rdy);
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd[ADDR_W-1:0] !== value)
        begin
            $error("heap_base readback: expected %h, got %h", value, rd[ADDR_W-1:0]);
            fail_count++;
        end
    endtask

    task automatic test_small_allocations();
        alloc_result_t r;
        send_request(ffca_pkg::CMD_ALLOC, '0, '0, r);
        send_request(ffca_pkg::CMD_ALLOC, SIZE_W'(CHUNK_BYTES - 1), ADDR_MAX, r);
        send_request(ffca_pkg::CMD_ALLOC, SIZE_W'(CHUNK_BYTES), '0, r);
        send_request(ffca_pkg::CMD_ALLOC, SIZE_W'(4 * CHUNK_BYTES - 1), '0, r);
        // unaligned free of chunk 1 pulls the hint down
        send_request(ffca_pkg::CMD_FREE, SIZE_W'(CHUNK_BYTES), ADDR_W'(CHUNK_BYTES + 5), r);
        // run does not start at the hint, hint stays
        send_request(ffca_pkg::CMD_ALLOC, SIZE_W'(2 * CHUNK_BYTES), '0, r);
        send_request(ffca_pkg::CMD_ALLOC, SIZE_W'(CHUNK_BYTES), '0, r);
    endtask

    task automatic test_free_edge_cases();
        alloc_result_t r;
        send_request(ffca_pkg::CMD_FREE, SIZE_W'(100), ADDR_W'(10 * CHUNK_BYTES), r);
        send_request(ffca_pkg::CMD_FREE, SIZE_W'(4 * CHUNK_BYTES),
                     ADDR_W'(500 * CHUNK_BYTES), r);
        send_request(ffca_pkg::CMD_FREE, SIZE_W'(3 * CHUNK_BYTES),
                     ADDR_W'(1022 * CHUNK_BYTES), r);
        send_request(ffca_pkg::CMD_FREE, SIZE_W'(CHUNK_BYTES), ADDR_W'(POOL_BYTES), r);
        send_request(ffca_pkg::CMD_FREE, SIZE_W'(POOL_BYTES), ADDR_MAX, r);
    endtask

    task automatic test_full_pool();
        alloc_result_t r;
        send_request(ffca_pkg::CMD_ALLOC, SIZE_W'(POOL_BYTES), '0, r);
        send_request(ffca_pkg::CMD_FREE, SIZE_W'(POOL_BYTES), '0, r);
        send_request(ffca_pkg::CMD_ALLOC, SIZE_W'(POOL_BYTES), '0, r);
        send_request(ffca_pkg::CMD_ALLOC, SIZE_W'(CHUNK_BYTES), '0, r);
        send_request(ffca_pkg::CMD_FREE, SIZE_W'(CHUNK_BYTES),
                     ADDR_W'((CHUNK_TOTAL - 1) * CHUNK_BYTES), r);
        send_request(ffca_pkg::CMD_ALLOC, SIZE_W'(CHUNK_BYTES), '0, r);
        send_request(ffca_pkg::CMD_FREE, SIZE_W'(POOL_BYTES), '0, r);
    endtask

    task automatic test_top_heap_base();
        alloc_result_t r;
        drain_results();
        write_heap_base(ADDR_MAX);
        send_request(ffca_pkg::CMD_FREE, SIZE_W'(CHUNK_BYTES), '0, r);
        send_request(ffca_pkg::CMD_ALLOC, SIZE_W'(CHUNK_BYTES), '0, r);
        // second chunk address wraps past the top of the address space
        send_request(ffca_pkg::CMD_ALLOC, SIZE_W'(CHUNK_BYTES), '0, r);
        send_request(ffca_pkg::CMD_FREE, SIZE_W'(POOL_BYTES), ADDR_MAX, r);
    endtask

    task automatic test_random_traffic(input logic [ADDR_W-1:0] base, input int count);
        alloc_result_t r;
        region_t picked;
        int sel;
        int n;
        int k;
        int quiet_from;
        drain_results();
        write_heap_base(base);
        send_request(ffca_pkg::CMD_FREE, SIZE_W'(POOL_BYTES), model_base, r);
        live_regions.delete();
        quiet_from = $urandom_range(10, count - 40);
        for (int i = 0; i < count; i++)
        begin
            source_quiet = (i >= quiet_from && i < quiet_from + 30);
            sink_quiet = source_quiet;
            sel = $urandom_range(0, 99);
            if (sel < 55 || (sel < 85 && live_regions.size() == 0))
            begin
                k = $urandom_range(0, 99);
                n = (k < 80) ? $urandom_range(1, 8) :
                    (k < 97) ? $urandom_range(9, 64) : $urandom_range(65, CHUNK_TOTAL);
                send_request(ffca_pkg::CMD_ALLOC, chunk_bytes_of(n), random_address(), r);
                if (r.status == ffca_pkg::STATUS_OK)
                begin
                    picked.first = int'(r.chunk_index);
                    picked.count = n;
                    live_regions.push_back(picked);
                end
            end
            else if (sel < 85)
            begin
                k = $urandom_range(0, live_regions.size() - 1);
                picked = live_regions[k];
                live_regions.delete(k);
                // now and then only part of the run goes back
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, picked.count)
                                                : picked.count;
                send_request(ffca_pkg::CMD_FREE, chunk_bytes_of(n),
                             ADDR_W'(model_base + picked.first * CHUNK_BYTES +
                                     $urandom_range(0, CHUNK_BYTES - 1)), r);
            end
            else if (sel < 90)
                send_request(ffca_pkg::CMD_FREE, SIZE_W'($urandom_range(0, POOL_BYTES)),
                             random_address(), r);
            else if (sel < 94)
                send_request(ffca_pkg::CMD_ALLOC, SIZE_W'($urandom_range(0, CHUNK_BYTES - 1)),
                             random_address(), r);
            else if (sel < 97)
                send_request(ffca_pkg::CMD_ALLOC, SIZE_W'($urandom_range(0, POOL_BYTES)),
                             random_address(), r);
            else
                send_request(ffca_pkg::CMD_FREE, chunk_bytes_of($urandom_range(0, 64)),
                             ADDR_W'(model_base +
                                     $urandom_range(0, CHUNK_TOTAL - 1) * CHUNK_BYTES +
                                     $urandom_range(0, CHUNK_BYTES - 1)), r);
        end
        source_quiet = 1'b0;
        sink_quiet = 1'b0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        command <= ffca_pkg::CMD_ALLOC;
        byte_size <= '0;
        free_address <= '0;
        cycle_count = 0;
        fail_count = 0;
        source_quiet = 1'b0;
        sink_quiet = 1'b0;
        scan_hint = 0;
        model_base = '0;
        foreach (chunk_used[i])
            chunk_used[i] = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_small_allocations();
        test_free_edge_cases();
        test_full_pool();
        test_top_heap_base();
        test_random_traffic('0, 140);
        test_random_traffic(random_address(), 140);
        test_random_traffic(ADDR_W'(ADDR_MAX - 300 * CHUNK_BYTES +
                                    $urandom_range(0, CHUNK_BYTES - 1)), 140);
        test_random_traffic(ADDR_W'($urandom), 140);

        drain_results();
        repeat (2 * CHUNK_TOTAL + 64) @(posedge clk);

        $display("ran %0d requests across %0d heap base settings", request_count, base_writes);
        $display("%0d allocations granted, %0d frees done, %0d out of room, %0d rejected",
                 alloc_granted, frees_done, no_room_seen, bad_seen);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
